[src/rg_pkg.sv]
// ----------------------------------------------------------------------------
// Ray generator package
// Shared constants, register indexes and width helpers for the ray generator.
// ----------------------------------------------------------------------------
`default_nettype none

package rg_pkg;

    localparam int PIX_W       = 12;
    localparam int DIM_W       = 13;
    localparam int ROW_W       = 48;
    localparam int COEF_W      = 16;
    localparam int RAY_W       = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int DEF_COORD_BITS = 12;
    localparam int DEF_FRAC_BITS  = 14;

    localparam logic [DIM_W-1:0] RST_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0] RST_HEIGHT = 13'd480;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_ROT_ROW0      = 3'd2,
        REG_ROT_ROW1      = 3'd3,
        REG_ROT_ROW2      = 3'd4
    } cfg_reg_t;

    function automatic int vec_w(input int coord_bits);
        int cb;
        cb = (coord_bits < PIX_W) ? coord_bits : PIX_W;
        return (((cb + 1) > DIM_W) ? (cb + 1) : DIM_W) + 1;
    endfunction

    function automatic int quad_w(input int coord_bits);
        return 2 * vec_w(coord_bits);
    endfunction

    function automatic int mag_w(input int coord_bits);
        return vec_w(coord_bits) + COEF_W;
    endfunction

    function automatic int digit_w(input int frac_bits);
        return (frac_bits < 15) ? frac_bits : 15;
    endfunction

    function automatic int rem_w(input int coord_bits, input int frac_bits);
        int a;
        int b;
        a = 2 * mag_w(coord_bits) + 3;
        b = 2 * digit_w(frac_bits) + quad_w(coord_bits) + 4;
        return ((a > b) ? a : b) + 1;
    endfunction

    function automatic int ray_limit(input int frac_bits);
        return (frac_bits < 15) ? (1 << frac_bits) : 32767;
    endfunction

endpackage

`default_nettype wire

[src/pinhole_camera_ray_generator_core.sv]
// ----------------------------------------------------------------------------
// Pinhole camera ray generator
// Turns a pixel coordinate into a rotated unit ray direction in signed fixed
// point, rounded to nearest and saturated.
//
//   Channel   Ports                         Direction
//   input     s_valid s_ready s_pixel_*     in
//   result    m_valid m_ready m_ray_dir_*   out
//   config    cfg_wr_en cfg_index cfg_wdata in
//
// One item enters per cycle while the result side is not stalled; the pipeline is
// the four front stages, one root stage per result bit and the output stage.
// Reset empties the pipeline and restores the default screen and identity.
// A stall on the result side freezes every stage at once, so nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module pinhole_camera_ray_generator_core #(
    parameter int COORD_BITS = rg_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = rg_pkg::DEF_FRAC_BITS
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [rg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rg_pkg::ROW_W-1:0]      cfg_wdata,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [rg_pkg::PIX_W-1:0]      s_pixel_x,
    input  wire logic [rg_pkg::PIX_W-1:0]      s_pixel_y,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic signed [rg_pkg::RAY_W-1:0]    m_ray_dir_x,
    output logic signed [rg_pkg::RAY_W-1:0]    m_ray_dir_y,
    output logic signed [rg_pkg::RAY_W-1:0]    m_ray_dir_z
);
    import rg_pkg::*;

    localparam int QW = quad_w(COORD_BITS);
    localparam int RW = rem_w(COORD_BITS, FRAC_BITS);
    localparam int MB = digit_w(FRAC_BITS);
    localparam logic [MB:0] LIMIT = (MB+1)'(ray_limit(FRAC_BITS));

    logic [DIM_W-1:0]  width_reg;
    logic [DIM_W-1:0]  height_reg;
    logic [ROW_W-1:0]  rows_reg [3];
    logic              adv;

    logic                 c_valid [MB+1];
    logic                 c_zero  [MB+1];
    logic [2:0]           c_neg   [MB+1];
    logic [QW-1:0]        c_q     [MB+1];
    logic signed [RW-1:0] c_rem   [MB+1][3];
    logic [RW-1:0]        c_oq    [MB+1][3];
    logic [MB-1:0]        c_m     [MB+1][3];

    logic                 out_valid_reg;
    logic signed [RAY_W-1:0] ray_reg [3];
    logic signed [RAY_W-1:0] ray_next [3];
    logic [MB:0]          mag_next [3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg   <= RST_WIDTH;
            height_reg  <= RST_HEIGHT;
            rows_reg[0] <= ROW_W'(1) << (2*COEF_W + FRAC_BITS);
            rows_reg[1] <= ROW_W'(1) << (COEF_W + FRAC_BITS);
            rows_reg[2] <= ROW_W'(1) << FRAC_BITS;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg   <= cfg_wdata[DIM_W-1:0];
                REG_SCREEN_HEIGHT: height_reg  <= cfg_wdata[DIM_W-1:0];
                REG_ROT_ROW0:      rows_reg[0] <= cfg_wdata;
                REG_ROT_ROW1:      rows_reg[1] <= cfg_wdata;
                REG_ROT_ROW2:      rows_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = adv;

    rg_front #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .pixel_x   (s_pixel_x),
        .pixel_y   (s_pixel_y),
        .width     (width_reg),
        .height    (height_reg),
        .rows      (rows_reg),
        .out_valid (c_valid[0]),
        .out_zero  (c_zero[0]),
        .out_neg   (c_neg[0]),
        .out_q     (c_q[0]),
        .out_rem   (c_rem[0])
    );

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            c_oq[0][i] = RW'(c_q[0]);
            c_m[0][i]  = '0;
        end
    end

    for (genvar k = 0; k < MB; k++) begin : g_root
        rg_root_stage #(
            .QW  (QW),
            .RW  (RW),
            .MB  (MB),
            .POS (MB - 1 - k)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (c_valid[k]),
            .in_zero   (c_zero[k]),
            .in_neg    (c_neg[k]),
            .in_q      (c_q[k]),
            .in_rem    (c_rem[k]),
            .in_oq     (c_oq[k]),
            .in_m      (c_m[k]),
            .out_valid (c_valid[k+1]),
            .out_zero  (c_zero[k+1]),
            .out_neg   (c_neg[k+1]),
            .out_q     (c_q[k+1]),
            .out_rem   (c_rem[k+1]),
            .out_oq    (c_oq[k+1]),
            .out_m     (c_m[k+1])
        );
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag_next[i] = (MB+1)'(c_m[MB][i]) + (MB+1)'(1);
            if (mag_next[i] > LIMIT) begin
                mag_next[i] = LIMIT;
            end
            if (c_zero[MB] || c_rem[MB][i][RW-1]) begin
                ray_next[i] = '0;
            end else if (c_neg[MB][i]) begin
                ray_next[i] = -RAY_W'(mag_next[i]);
            end else begin
                ray_next[i] = RAY_W'(mag_next[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= c_valid[MB];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ray_reg <= ray_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_ray_dir_x = ray_reg[0];
    assign m_ray_dir_y = ray_reg[1];
    assign m_ray_dir_z = ray_reg[2];

endmodule

`default_nettype wire

[src/rg_front.sv]
// ----------------------------------------------------------------------------
// Ray generator front end
// Forms the doubled view vector, rotates it and prepares the root remainders.
// ----------------------------------------------------------------------------
`default_nettype none

module rg_front #(
    parameter int COORD_BITS = rg_pkg::DEF_COORD_BITS,
    parameter int FRAC_BITS  = rg_pkg::DEF_FRAC_BITS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            adv,
    input  wire logic                            in_valid,
    input  wire logic [rg_pkg::PIX_W-1:0]        pixel_x,
    input  wire logic [rg_pkg::PIX_W-1:0]        pixel_y,
    input  wire logic [rg_pkg::DIM_W-1:0]        width,
    input  wire logic [rg_pkg::DIM_W-1:0]        height,
    input  wire logic [rg_pkg::ROW_W-1:0]        rows [3],
    output logic                                 out_valid,
    output logic                                 out_zero,
    output logic [2:0]                           out_neg,
    output logic [rg_pkg::quad_w(COORD_BITS)-1:0] out_q,
    output logic signed [rg_pkg::rem_w(COORD_BITS, FRAC_BITS)-1:0] out_rem [3]
);
    import rg_pkg::*;

    localparam int VW = vec_w(COORD_BITS);
    localparam int QW = quad_w(COORD_BITS);
    localparam int MW = mag_w(COORD_BITS);
    localparam int RW = rem_w(COORD_BITS, FRAC_BITS);
    localparam int PW = VW + COEF_W;
    localparam logic [PIX_W-1:0] XMASK =
        (COORD_BITS >= PIX_W) ? {PIX_W{1'b1}} : PIX_W'((1 << COORD_BITS) - 1);

    logic [PIX_W-1:0]       xm;
    logic [PIX_W-1:0]       ym;
    logic signed [VW-1:0]   v [3];
    logic signed [COEF_W-1:0] coef [3][3];

    logic                   v1_reg;
    logic signed [PW-1:0]   prod_reg [3][3];
    logic [2*VW-1:0]        sq_reg [3];

    logic                   v2_reg;
    logic [MW-1:0]          mag_reg [3];
    logic [2:0]             neg2_reg;
    logic [QW-1:0]          q2_reg;

    logic                   v3_reg;
    logic [2*MW-1:0]        msq_reg [3];
    logic [2:0]             neg3_reg;
    logic [QW-1:0]          q3_reg;

    logic                   v4_reg;
    logic signed [RW-1:0]   rem_reg [3];
    logic [2:0]             neg4_reg;
    logic [QW-1:0]          q4_reg;

    logic signed [MW:0]     sum_next [3];

    always_comb begin
        xm   = pixel_x & XMASK;
        ym   = pixel_y & XMASK;
        v[0] = VW'({xm, 1'b0}) - VW'(width);
        v[1] = VW'(height) - VW'({ym, 1'b0});
        v[2] = VW'(width);
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                coef[i][j] = rows[i][ROW_W-1-COEF_W*j -: COEF_W];
            end
        end
        for (int i = 0; i < 3; i++) begin
            sum_next[i] = (MW+1)'(prod_reg[i][0]) + (MW+1)'(prod_reg[i][1])
                        + (MW+1)'(prod_reg[i][2]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    prod_reg[i][j] <= PW'(coef[i][j]) * PW'(v[j]);
                end
                sq_reg[i] <= (2*VW)'(v[i] * v[i]);
            end
            for (int i = 0; i < 3; i++) begin
                neg2_reg[i] <= sum_next[i][MW];
                mag_reg[i]  <= sum_next[i][MW] ? MW'(-sum_next[i]) : MW'(sum_next[i]);
            end
            q2_reg <= QW'(sq_reg[0]) + QW'(sq_reg[1]) + QW'(sq_reg[2]);
            for (int i = 0; i < 3; i++) begin
                msq_reg[i] <= mag_reg[i] * mag_reg[i];
            end
            neg3_reg <= neg2_reg;
            q3_reg   <= q2_reg;
            for (int i = 0; i < 3; i++) begin
                rem_reg[i] <= RW'({msq_reg[i], 2'b00}) - RW'(q3_reg);
            end
            neg4_reg <= neg3_reg;
            q4_reg   <= q3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_zero  = (q4_reg == '0);
    assign out_neg   = neg4_reg;
    assign out_q     = q4_reg;
    assign out_rem   = rem_reg;

endmodule

`default_nettype wire

[src/rg_root_stage.sv]
// ----------------------------------------------------------------------------
// Ray generator root stage
// Settles one quotient bit of the normalized ray for all three components.
// ----------------------------------------------------------------------------
`default_nettype none

module rg_root_stage #(
    parameter int QW  = 28,
    parameter int RW  = 68,
    parameter int MB  = 14,
    parameter int POS = 0
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 adv,
    input  wire logic                 in_valid,
    input  wire logic                 in_zero,
    input  wire logic [2:0]           in_neg,
    input  wire logic [QW-1:0]        in_q,
    input  wire logic signed [RW-1:0] in_rem [3],
    input  wire logic [RW-1:0]        in_oq [3],
    input  wire logic [MB-1:0]        in_m [3],
    output logic                      out_valid,
    output logic                      out_zero,
    output logic [2:0]                out_neg,
    output logic [QW-1:0]             out_q,
    output logic signed [RW-1:0]      out_rem [3],
    output logic [RW-1:0]             out_oq [3],
    output logic [MB-1:0]             out_m [3]
);

    logic                  valid_reg;
    logic                  zero_reg;
    logic [2:0]            neg_reg;
    logic [QW-1:0]         q_reg;
    logic signed [RW-1:0]  rem_reg [3];
    logic [RW-1:0]         oq_reg [3];
    logic [MB-1:0]         m_reg [3];

    logic [RW-1:0]         qe;
    logic signed [RW-1:0]  trial [3];

    always_comb begin
        qe = RW'(in_q);
        for (int i = 0; i < 3; i++) begin
            trial[i] = in_rem[i] - $signed((in_oq[i] << (POS + 2)) + (qe << (2*POS + 2)));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            zero_reg <= in_zero;
            neg_reg  <= in_neg;
            q_reg    <= in_q;
            for (int i = 0; i < 3; i++) begin
                if (!trial[i][RW-1]) begin
                    rem_reg[i] <= trial[i];
                    oq_reg[i]  <= in_oq[i] + (qe << (POS + 1));
                    m_reg[i]   <= in_m[i] | MB'(1 << POS);
                end else begin
                    rem_reg[i] <= in_rem[i];
                    oq_reg[i]  <= in_oq[i];
                    m_reg[i]   <= in_m[i];
                end
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_zero  = zero_reg;
    assign out_neg   = neg_reg;
    assign out_q     = q_reg;
    assign out_rem   = rem_reg;
    assign out_oq    = oq_reg;
    assign out_m     = m_reg;

endmodule

`default_nettype wire

[src/rg_checker.sv]
// ----------------------------------------------------------------------------
// Ray generator checker
// Port-level checks on the ray generator, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module rg_checker #(
    parameter int FRAC_BITS = rg_pkg::DEF_FRAC_BITS
) (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_ready,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [rg_pkg::RAY_W-1:0]    m_ray_dir_x,
    input wire logic [rg_pkg::RAY_W-1:0]    m_ray_dir_y,
    input wire logic [rg_pkg::RAY_W-1:0]    m_ray_dir_z
);
    import rg_pkg::*;

    localparam int LIM = ray_limit(FRAC_BITS);

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("Result valid right after reset.");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_ray_dir_x)
            && $stable(m_ray_dir_y) && $stable(m_ray_dir_z))
        else $error("Stalled result item changed.");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("Input ready does not follow the result side.");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ($signed(m_ray_dir_x) <= LIM) && ($signed(m_ray_dir_x) >= -LIM)
            && ($signed(m_ray_dir_y) <= LIM) && ($signed(m_ray_dir_y) >= -LIM)
            && ($signed(m_ray_dir_z) <= LIM) && ($signed(m_ray_dir_z) >= -LIM))
        else $error("Ray component beyond saturation bound.");

endmodule

bind pinhole_camera_ray_generator_core rg_checker #(
    .FRAC_BITS (FRAC_BITS)
) u_rg_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_ray_dir_x (m_ray_dir_x),
    .m_ray_dir_y (m_ray_dir_y),
    .m_ray_dir_z (m_ray_dir_z)
);

`default_nettype wire

[tb/pinhole_camera_ray_generator_core_tb.sv]
// ----------------------------------------------------------------------------
// Pinhole camera ray generator testbench
// Drives pixel items through the ray generator under random gaps and result
// stalls, predicts every ray from its own arithmetic model and checks each one.
// ----------------------------------------------------------------------------
module pinhole_camera_ray_generator_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rg_pkg::*;

    localparam int LATENCY = 5 + 14;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_UNUSED = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_UNUSED  = 3'd7;
    localparam logic [COEF_W-1:0] COEF_ONE = 16'h4000;
    localparam logic [COEF_W-1:0] COEF_MAX = 16'h7fff;
    localparam logic [COEF_W-1:0] COEF_MIN = 16'h8000;

    typedef struct packed {
        logic signed [RAY_W-1:0] dx;
        logic signed [RAY_W-1:0] dy;
        logic signed [RAY_W-1:0] dz;
    } ray_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ROW_W-1:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [PIX_W-1:0] s_pixel_x = '0;
    logic [PIX_W-1:0] s_pixel_y = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [RAY_W-1:0] m_ray_dir_x;
    logic signed [RAY_W-1:0] m_ray_dir_y;
    logic signed [RAY_W-1:0] m_ray_dir_z;

    logic [DIM_W-1:0] scr_w = RST_WIDTH;
    logic [DIM_W-1:0] scr_h = RST_HEIGHT;
    logic [ROW_W-1:0] rot [3];

    ray_t pending_rays[$];
    int errors = 0;
    int rays_checked = 0;
    int pixels_sent = 0;
    int settings_used = 0;
    bit stall_enable = 1'b1;
    int stall_left = 0;

    pinhole_camera_ray_generator_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_pixel_x(s_pixel_x), .s_pixel_y(s_pixel_y),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_ray_dir_x(m_ray_dir_x), .m_ray_dir_y(m_ray_dir_y), .m_ray_dir_z(m_ray_dir_z)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic logic [RAY_W-1:0] unit_component(longint s, longint q);
        logic [127:0] target;
        logic [127:0] trial;
        longint mag;
        longint lo;
        longint hi;
        longint mid;
        if (q == 0) return '0;
        mag = (s < 0) ? -s : s;
        target = 128'(2 * mag) * 128'(2 * mag);
        lo = 0;
        hi = ray_limit(DEF_FRAC_BITS);
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            trial = 128'(2 * mid - 1) * 128'(2 * mid - 1) * 128'(q);
            if (trial <= target) lo = mid;
            else hi = mid - 1;
        end
        return (s < 0) ? RAY_W'(-lo) : RAY_W'(lo);
    endfunction

    function automatic ray_t predict_ray(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py);
        longint v [3];
        longint q;
        longint s;
        logic [RAY_W-1:0] c [3];
        ray_t r;
        v[0] = 2 * longint'(px) - longint'(scr_w);
        v[1] = longint'(scr_h) - 2 * longint'(py);
        v[2] = longint'(scr_w);
        q = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
        for (int i = 0; i < 3; i++) begin
            s = 0;
            for (int j = 0; j < 3; j++)
                s += longint'($signed(rot[i][47 - 16 * j -: 16])) * v[j];
            c[i] = unit_component(s, q);
        end
        r.dx = c[0];
        r.dy = c[1];
        r.dz = c[2];
        return r;
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            pending_rays.push_back(predict_ray(s_pixel_x, s_pixel_y));
    end

    always @(posedge aclk) begin
        ray_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rays.size() == 0) begin
                $error("unexpected ray x=%0d y=%0d z=%0d", m_ray_dir_x, m_ray_dir_y,
                       m_ray_dir_z);
                errors++;
            end else begin
                want = pending_rays.pop_front();
                rays_checked++;
                if (m_ray_dir_x !== want.dx) begin
                    $error("ray_dir_x expected %0d actual %0d", want.dx, m_ray_dir_x);
                    errors++;
                end
                if (m_ray_dir_y !== want.dy) begin
                    $error("ray_dir_y expected %0d actual %0d", want.dy, m_ray_dir_y);
                    errors++;
                end
                if (m_ray_dir_z !== want.dz) begin
                    $error("ray_dir_z expected %0d actual %0d", want.dz, m_ray_dir_z);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        int r;
        if (!stall_enable) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b0;
                stall_left = (r < 95) ? $urandom_range(0, 3) : $urandom_range(10, 60);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_pixel(logic [PIX_W-1:0] px, logic [PIX_W-1:0] py, int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_pixel_x <= px;
        s_pixel_y <= py;
        do @(posedge aclk); while (!s_ready);
        pixels_sent++;
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_rays.size() != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [ROW_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_SCREEN_WIDTH:  scr_w = val[DIM_W-1:0];
            REG_SCREEN_HEIGHT: scr_h = val[DIM_W-1:0];
            REG_ROT_ROW0:      rot[0] = val;
            REG_ROT_ROW1:      rot[1] = val;
            REG_ROT_ROW2:      rot[2] = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_camera(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                              logic [ROW_W-1:0] r0, logic [ROW_W-1:0] r1,
                              logic [ROW_W-1:0] r2);
        write_reg(REG_SCREEN_WIDTH, ROW_W'(w));
        write_reg(REG_SCREEN_HEIGHT, ROW_W'(h));
        write_reg(REG_ROT_ROW0, r0);
        write_reg(REG_ROT_ROW1, r1);
        write_reg(REG_ROT_ROW2, r2);
        settings_used++;
    endtask

    function automatic logic [ROW_W-1:0] random_row();
        return {$urandom, 16'($urandom)};
    endfunction

    function automatic logic [ROW_W-1:0] pack_row(logic [COEF_W-1:0] a, logic [COEF_W-1:0] b,
                                                  logic [COEF_W-1:0] c);
        return {a, b, c};
    endfunction

    task automatic test_reset_corners();
        send_pixel(0, 0, 0);
        send_pixel(639, 479, 0);
        send_pixel(320, 240, 1);
        send_pixel(0, 479, 0);
        send_pixel(639, 0, 2);
        send_pixel(12'hfff, 12'hfff, 0);
        send_pixel(12'hfff, 0, 0);
        send_pixel(0, 12'hfff, 0);
        drain();
    endtask

    task automatic test_zero_direction();
        set_camera(0, 480, pack_row(COEF_ONE, 0, 0), pack_row(0, COEF_ONE, 0),
                   pack_row(0, 0, COEF_ONE));
        send_pixel(0, 240, 0);
        send_pixel(0, 0, 0);
        send_pixel(5, 240, 0);
        drain();
        write_reg(REG_SCREEN_HEIGHT, 0);
        send_pixel(0, 0, 0);
        send_pixel(12'hfff, 12'hfff, 0);
        drain();
    endtask

    task automatic test_saturation();
        set_camera(13'h1fff, 13'h1fff, pack_row(COEF_MAX, COEF_MAX, COEF_MAX),
                   pack_row(COEF_MIN, COEF_MIN, COEF_MIN), pack_row(COEF_MAX, COEF_MIN, 0));
        send_pixel(12'hfff, 0, 0);
        send_pixel(0, 12'hfff, 0);
        send_pixel(12'hfff, 12'hfff, 0);
        send_pixel(0, 0, 1);
        drain();
        set_camera(1, 1, pack_row(COEF_MIN, 0, 0), pack_row(0, COEF_MIN, 0),
                   pack_row(0, 0, COEF_MIN));
        send_pixel(0, 0, 0);
        send_pixel(1, 1, 0);
        drain();
    endtask

    task automatic test_unused_index();
        for (int i = REG_FIRST_UNUSED; i <= REG_LAST_UNUSED; i++)
            write_reg(CFG_IDX_W'(i), '1);
        send_pixel(3, 7, 0);
        send_pixel(12'hfff, 12'h800, 0);
        drain();
    endtask

    task automatic test_random_scenes(int scenes, int per_scene);
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        int r;
        for (int sc = 0; sc < scenes; sc++) begin
            r = $urandom_range(0, 9);
            w = (r == 0) ? 13'd1 : (r == 1) ? 13'd4096 : (r == 2) ? 13'h1fff
                : DIM_W'($urandom_range(1, 4096));
            r = $urandom_range(0, 9);
            h = (r == 0) ? 13'd1 : (r == 1) ? 13'd4096 : (r == 2) ? 13'h1fff
                : DIM_W'($urandom_range(1, 4096));
            if ($urandom_range(0, 1))
                set_camera(w, h, random_row(), random_row(), random_row());
            else
                set_camera(w, h, pack_row(0, COEF_ONE, 0), pack_row(COEF_MIN, 0, 0),
                           pack_row(0, 0, COEF_ONE));
            stall_enable = (sc % 4 != 3);
            for (int k = 0; k < per_scene; k++) begin
                if ($urandom_range(0, 9) < 8) begin
                    px = PIX_W'($urandom_range(0, (w > 4096) ? 4095 : w - 1));
                    py = PIX_W'($urandom_range(0, (h > 4096) ? 4095 : h - 1));
                end else begin
                    px = PIX_W'($urandom);
                    py = PIX_W'($urandom);
                end
                send_pixel(px, py, stall_enable ? pick_gap() : 0);
            end
            drain();
        end
        stall_enable = 1'b1;
    endtask

    initial begin
        rot[0] = pack_row(COEF_ONE, 0, 0);
        rot[1] = pack_row(0, COEF_ONE, 0);
        rot[2] = pack_row(0, 0, COEF_ONE);
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);
        test_reset_corners();
        test_zero_direction();
        test_saturation();
        test_unused_index();
        test_random_scenes(25, 50);
        $display("Sent %0d pixels over %0d camera settings, checked %0d rays.",
                 pixels_sent, settings_used, rays_checked);
        $display("Covered zero direction, saturation, off-screen pixels and stalls.");
        if (errors == 0 && pending_rays.size() == 0) begin
            $display("[pinhole_camera_ray_generator_core] OK");
        end else begin
            $display("[pinhole_camera_ray_generator_core] ERROR");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("[pinhole_camera_ray_generator_core] ERROR");
        $finish;
    end
endmodule
